>>> hw/rtl/isi_pkg.sv
// Shared types and constants of the Ising Metropolis spin update block.
// No dependencies; imported by every RTL file of the block.
`default_nettype none

package isi_pkg;

  localparam int CoordW  = 5;
  localparam int RandW   = 16;
  localparam int ThrW    = 17;
  localparam int DeW     = 5;
  localparam int EnW     = 13;
  localparam int MagW    = 12;
  localparam int CfgIdxW = 2;

  localparam logic [1:0] REQ_STEP  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  localparam logic [CfgIdxW-1:0] CFG_THR_DE4 = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CFG_THR_DE8 = CfgIdxW'(1);

  localparam logic [ThrW-1:0] THR_DE4_RESET = ThrW'(8869);
  localparam logic [ThrW-1:0] THR_DE8_RESET = ThrW'(1200);

  // write side of the lattice store
  typedef struct packed {
    logic we;
    logic wdata;
  } lat_ctl_t;

endpackage

`default_nettype wire

>>> hw/rtl/isi_lattice.sv
// Spin lattice store: one-bit memory, one write and one registered read port.
// Runs a clearing pass to all +1 after reset. Uses isi_pkg.
`default_nettype none

module isi_lattice
  import isi_pkg::*;
#(
  parameter int Depth = 1024,
  localparam int AW = $clog2(Depth)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire lat_ctl_t      lat_ctl_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic               rdata_o,
  output logic               ready_o
);

  logic          mem [Depth];
  logic          clr_busy_q;
  logic [AW-1:0] clr_addr_q;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic          mem_wd;

  assign mem_we  = clr_busy_q | lat_ctl_i.we;
  assign mem_wa  = clr_busy_q ? clr_addr_q : waddr_i;
  assign mem_wd  = clr_busy_q | lat_ctl_i.wdata;
  assign ready_o = ~clr_busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + AW'(1);
      if (clr_addr_q == AW'(Depth - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

>>> hw/rtl/ising_metropolis_spin_update.sv
// One item at a time; five serial reads on the single lattice read port.
// Reset: lattice clearing pass, busy high while it runs; config taken.
// The receiver cannot stall: each result is shown for one cycle only.
// Uses isi_pkg and isi_lattice.
`default_nettype none

module ising_metropolis_spin_update
  import isi_pkg::*;
#(
  parameter int SIDE = 32
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  output logic                     busy_o,
  input  wire logic [1:0]          req_type_i,
  input  wire logic [CoordW-1:0]   row_i,
  input  wire logic [CoordW-1:0]   column_i,
  input  wire logic [RandW-1:0]    random_fraction_i,
  input  wire logic                spin_value_i,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [ThrW-1:0]     cfg_data_i,
  output logic                     result_valid_o,
  output logic                     accepted_o,
  output logic                     spin_after_o,
  output logic signed [DeW-1:0]    delta_energy_o,
  output logic signed [EnW-1:0]    total_energy_o,
  output logic signed [MagW-1:0]   total_magnetization_o
);

  localparam int Depth = SIDE * SIDE;
  localparam int AW    = $clog2(Depth);
  localparam int CW    = $clog2(SIDE);
  localparam int SW    = (CW > CoordW) ? CW + 1 : CoordW + 1;

  localparam logic [EnW-1:0]  EnReset  = EnW'(-2 * SIDE * SIDE);
  localparam logic [MagW-1:0] MagReset = MagW'(SIDE * SIDE);
  localparam logic [MagW-1:0] MagUp    = MagW'(2);
  localparam logic [MagW-1:0] MagDown  = MagW'(-2);
  localparam logic [DeW-1:0]  DeFour   = DeW'(4);
  localparam logic [DeW-1:0]  DeEight  = DeW'(8);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EVAL
  } state_e;

  state_e            state_q;
  logic [2:0]        cnt_q;
  logic [1:0]        req_q;
  logic [CW-1:0]     row_q;
  logic [CW-1:0]     col_q;
  logic [RandW-1:0]  rnd_q;
  logic              want_q;
  logic              oob_q;
  logic              center_q;
  logic [2:0]        ones_q;
  logic [ThrW-1:0]   thr4_q;
  logic [ThrW-1:0]   thr8_q;
  logic [EnW-1:0]    en_q;
  logic [MagW-1:0]   mag_q;

  logic              lat_ready;
  logic              lat_rdata;
  lat_ctl_t          lat_ctl;
  logic [AW-1:0]     ctr_addr;
  logic [AW-1:0]     rd_addr;
  logic [CW-1:0]     row_up;
  logic [CW-1:0]     row_dn;
  logic [CW-1:0]     col_up;
  logic [CW-1:0]     col_dn;
  logic              in_oob;
  logic              start_ok;
  logic [DeW-1:0]    ones_x4;
  logic [DeW-1:0]    de;
  logic              acc;

  assign busy_o      = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign start_ok    = start_i & ~busy_o;

  assign in_oob = (SW'(row_i) >= SW'(SIDE)) | (SW'(column_i) >= SW'(SIDE));

  assign row_up = (row_q == CW'(SIDE - 1)) ? '0 : row_q + CW'(1);
  assign row_dn = (row_q == '0) ? CW'(SIDE - 1) : row_q - CW'(1);
  assign col_up = (col_q == CW'(SIDE - 1)) ? '0 : col_q + CW'(1);
  assign col_dn = (col_q == '0) ? CW'(SIDE - 1) : col_q - CW'(1);

  assign ctr_addr = AW'(row_q) * AW'(SIDE) + AW'(col_q);

  always_comb begin
    unique case (cnt_q)
      3'd1:    rd_addr = AW'(row_up) * AW'(SIDE) + AW'(col_q);
      3'd2:    rd_addr = AW'(row_dn) * AW'(SIDE) + AW'(col_q);
      3'd3:    rd_addr = AW'(row_q) * AW'(SIDE) + AW'(col_up);
      3'd4:    rd_addr = AW'(row_q) * AW'(SIDE) + AW'(col_dn);
      default: rd_addr = ctr_addr;
    endcase
  end

  // dE = 2*s*(2n-4) with n the count of +1 neighbours
  assign ones_x4 = {ones_q, 2'b00};
  assign de      = center_q ? ones_x4 - DeEight : DeEight - ones_x4;

  always_comb begin
    acc = 1'b0;
    if (!oob_q) begin
      unique case (req_q)
        REQ_STEP: begin
          if (de[DeW-1] || de == '0) begin
            acc = 1'b1;
          end else if (de == DeFour) begin
            acc = ({1'b0, rnd_q} < thr4_q);
          end else begin
            acc = ({1'b0, rnd_q} < thr8_q);
          end
        end
        REQ_WRITE: acc = (want_q != center_q);
        default:   acc = 1'b0;
      endcase
    end
  end

  assign lat_ctl.we    = (state_q == ST_EVAL) & acc;
  assign lat_ctl.wdata = ~center_q;

  isi_lattice #(
    .Depth(Depth)
  ) u_lattice (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .lat_ctl_i(lat_ctl),
    .waddr_i  (ctr_addr),
    .raddr_i  (rd_addr),
    .rdata_o  (lat_rdata),
    .ready_o  (lat_ready)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr4_q <= THR_DE4_RESET;
      thr8_q <= THR_DE8_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_THR_DE4: thr4_q <= cfg_data_i;
        CFG_THR_DE8: thr8_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_CLEAR;
      cnt_q          <= '0;
      en_q           <= EnReset;
      mag_q          <= MagReset;
      result_valid_o <= 1'b0;
      oob_q          <= 1'b0;
      ones_q         <= '0;
    end else begin
      result_valid_o <= 1'b0;
      unique case (state_q)
        ST_CLEAR: begin
          if (lat_ready) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start_ok) begin
            req_q  <= req_type_i;
            row_q  <= CW'(row_i);
            col_q  <= CW'(column_i);
            rnd_q  <= random_fraction_i;
            want_q <= spin_value_i;
            oob_q  <= in_oob;
            ones_q <= '0;
            cnt_q  <= '0;
            state_q <= in_oob ? ST_EVAL : ST_READ;
          end
        end
        ST_READ: begin
          cnt_q <= cnt_q + 3'd1;
          if (cnt_q == 3'd1) begin
            center_q <= lat_rdata;
          end
          if (cnt_q >= 3'd2) begin
            ones_q <= ones_q + {2'b00, lat_rdata};
          end
          if (cnt_q == 3'd5) begin
            state_q <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          result_valid_o <= 1'b1;
          accepted_o     <= acc;
          spin_after_o   <= oob_q ? 1'b0 : (center_q ^ acc);
          delta_energy_o <= oob_q ? '0 : de;
          if (acc) begin
            en_q  <= en_q + {{(EnW - DeW){de[DeW-1]}}, de};
            mag_q <= mag_q + (center_q ? MagDown : MagUp);
            total_energy_o        <= en_q + {{(EnW - DeW){de[DeW-1]}}, de};
            total_magnetization_o <= mag_q + (center_q ? MagDown : MagUp);
          end else begin
            total_energy_o        <= en_q;
            total_magnetization_o <= mag_q;
          end
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/isi_checker.sv
// Port-level checker for ising_metropolis_spin_update, bound to the top level.
// Uses isi_pkg.
`default_nettype none

module isi_checker
  import isi_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                start_i,
  input wire logic                busy_o,
  input wire logic                result_valid_o,
  input wire logic signed [DeW-1:0] delta_energy_o
);

  // results are isolated one-cycle pulses
  a_strobe_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

  a_idle_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy_o)
    else $error("busy while result beat shown");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("start beat did not raise busy");

  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i))
    else $error("busy rose without start beat");

  a_de_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (delta_energy_o == -5'sd8 || delta_energy_o == -5'sd4 ||
                        delta_energy_o == 5'sd0 || delta_energy_o == 5'sd4 ||
                        delta_energy_o == 5'sd8))
    else $error("illegal energy change on result beat");

endmodule

bind ising_metropolis_spin_update isi_checker u_isi_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start_i       (start_i),
  .busy_o        (busy_o),
  .result_valid_o(result_valid_o),
  .delta_energy_o(delta_energy_o)
);

`default_nettype wire

>>> test/ising_metropolis_spin_update_tb.sv
// Self-checking testbench for ising_metropolis_spin_update: a queue-fed driver of
// step/write/read beats, a lattice predictor, and a result monitor.
// Depends on isi_pkg and the ising_metropolis_spin_update RTL.
`timescale 1ns / 100ps

module ising_metropolis_spin_update_tb;
  import isi_pkg::*;

  localparam int SIDE = 32;
  localparam int SITES = SIDE * SIDE;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_PHASES = 6;
  localparam int ITEMS_PER_PHASE = 155;
  localparam int MAX_PRINTED = 50;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam logic [CfgIdxW-1:0] CFG_UNUSED_A = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] CFG_UNUSED_B = CfgIdxW'(3);

  typedef struct packed {
    logic [1:0]        kind;
    logic [CoordW-1:0] row;
    logic [CoordW-1:0] col;
    logic [RandW-1:0]  rnd;
    logic              spin;
  } spin_req_t;

  typedef struct packed {
    logic                  accepted;
    logic                  spin_after;
    logic signed [DeW-1:0] de;
    logic signed [EnW-1:0] energy;
    logic signed [MagW-1:0] mag;
  } spin_update_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start_i = 1'b0;
  logic [1:0]          req_type_i = REQ_READ;
  logic [CoordW-1:0]   row_i = '0;
  logic [CoordW-1:0]   column_i = '0;
  logic [RandW-1:0]    random_fraction_i = '0;
  logic                spin_value_i = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [ThrW-1:0]     cfg_data_i = '0;
  logic                busy_o;
  logic                cfg_ready_o;
  logic                result_valid_o;
  logic                accepted_o;
  logic                spin_after_o;
  logic signed [DeW-1:0]  delta_energy_o;
  logic signed [EnW-1:0]  total_energy_o;
  logic signed [MagW-1:0] total_magnetization_o;

  ising_metropolis_spin_update #(
    .SIDE(SIDE)
  ) dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .start_i              (start_i),
    .busy_o               (busy_o),
    .req_type_i           (req_type_i),
    .row_i                (row_i),
    .column_i             (column_i),
    .random_fraction_i    (random_fraction_i),
    .spin_value_i         (spin_value_i),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_ready_o          (cfg_ready_o),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i),
    .result_valid_o       (result_valid_o),
    .accepted_o           (accepted_o),
    .spin_after_o         (spin_after_o),
    .delta_energy_o       (delta_energy_o),
    .total_energy_o       (total_energy_o),
    .total_magnetization_o(total_magnetization_o)
  );

  // predictor state
  bit              site_spin [SITES];
  int              energy_sum;
  int              magnet_sum;
  logic [ThrW-1:0] thr_de4;
  logic [ThrW-1:0] thr_de8;

  spin_req_t    pending_requests[$];
  spin_update_t expected_updates[$];
  spin_req_t    drive_req;
  int unsigned  idle_pct = 20;
  int unsigned  cycle_count = 0;
  int unsigned  error_count = 0;

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  function automatic int unsigned wrap_inc(int unsigned k);
    return (k + 1 >= SIDE) ? 0 : k + 1;
  endfunction

  function automatic int unsigned wrap_dec(int unsigned k);
    return (k == 0) ? SIDE - 1 : k - 1;
  endfunction

  function automatic int spin_of(int unsigned r, int unsigned c);
    return site_spin[r * SIDE + c] ? 1 : -1;
  endfunction

  function automatic spin_update_t predict_spin_update(spin_req_t req);
    spin_update_t upd;
    int           s;
    int           nsum;
    int           de;
    int unsigned  r;
    int unsigned  c;
    int unsigned  idx;
    bit           flip;
    upd = '0;
    de = 0;
    flip = 1'b0;
    r = req.row;
    c = req.col;
    if (r < SIDE && c < SIDE) begin
      idx = r * SIDE + c;
      s = spin_of(r, c);
      nsum = spin_of(wrap_inc(r), c) + spin_of(wrap_dec(r), c)
           + spin_of(r, wrap_inc(c)) + spin_of(r, wrap_dec(c));
      de = 2 * s * nsum;
      case (req.kind)
        REQ_STEP: begin
          if (de <= 0) flip = 1'b1;
          else if (de == 4) flip = (req.rnd < thr_de4);
          else flip = (req.rnd < thr_de8);
        end
        REQ_WRITE: begin
          flip = (req.spin != site_spin[idx]);
        end
        default: begin
          flip = 1'b0;
        end
      endcase
      if (flip) begin
        site_spin[idx] = ~site_spin[idx];
        energy_sum += de;
        magnet_sum += site_spin[idx] ? 2 : -2;
      end
      upd.accepted = flip;
      upd.spin_after = site_spin[idx];
    end
    upd.de = DeW'(de);
    upd.energy = EnW'(energy_sum);
    upd.mag = MagW'(magnet_sum);
    return upd;
  endfunction

  function automatic spin_req_t make_req(logic [1:0] kind, int unsigned r, int unsigned c,
                                         int unsigned rnd, bit spin);
    spin_req_t req;
    req.kind = kind;
    req.row = CoordW'(r);
    req.col = CoordW'(c);
    req.rnd = RandW'(rnd);
    req.spin = spin;
    return req;
  endfunction

  // Half the time a small patch around the wrap corner so neighbours interact, rest anywhere.
  function automatic spin_req_t random_req();
    spin_req_t   req;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 50) req.kind = REQ_STEP;
    else if (pick < 75) req.kind = REQ_WRITE;
    else if (pick < 95) req.kind = REQ_READ;
    else req.kind = REQ_UNUSED;
    if ($urandom_range(1) == 0) begin
      req.row = CoordW'(30 + $urandom_range(3));
      req.col = CoordW'(30 + $urandom_range(3));
    end else begin
      req.row = CoordW'($urandom);
      req.col = CoordW'($urandom);
    end
    case ($urandom_range(3))
      0: req.rnd = RandW'(thr_de4 - $urandom_range(1));
      1: req.rnd = RandW'(thr_de8 - $urandom_range(1));
      default: req.rnd = RandW'($urandom);
    endcase
    req.spin = 1'($urandom_range(1));
    return req;
  endfunction

  task automatic report_mismatch(input string msg);
    if (error_count < MAX_PRINTED) $display("MISMATCH cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  task automatic wait_quiet();
    do @(posedge clk_i);
    while (pending_requests.size() != 0 || start_i || expected_updates.size() != 0 || busy_o);
  endtask

  // Real registers first, then, if poke_unused, the unused indexes so an alias would clobber them.
  task automatic program_thresholds(input logic [ThrW-1:0] de4, input logic [ThrW-1:0] de8,
                                    input bit poke_unused);
    logic [CfgIdxW-1:0] idx [4];
    logic [ThrW-1:0]    val [4];
    int                 n;
    idx[0] = CFG_THR_DE4;
    idx[1] = CFG_THR_DE8;
    idx[2] = CFG_UNUSED_A;
    idx[3] = CFG_UNUSED_B;
    val[0] = de4;
    val[1] = de8;
    val[2] = ThrW'($urandom);
    val[3] = ThrW'($urandom);
    n = poke_unused ? 4 : 2;
    for (int i = 0; i < n; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i <= val[i];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      if (idx[i] == CFG_THR_DE4) thr_de4 = val[i];
      else if (idx[i] == CFG_THR_DE8) thr_de8 = val[i];
    end
    cfg_valid_i <= 1'b0;
  endtask

  // driver: a beat is taken on start_i && !busy_o
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      if (start_i && !busy_o) begin
        expected_updates.push_back(predict_spin_update(drive_req));
      end
      if (!(start_i && busy_o)) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= idle_pct) begin
          drive_req = pending_requests.pop_front();
          start_i <= 1'b1;
          req_type_i <= drive_req.kind;
          row_i <= drive_req.row;
          column_i <= drive_req.col;
          random_fraction_i <= drive_req.rnd;
          spin_value_i <= drive_req.spin;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    spin_update_t exp_upd;
    if (rst_ni && result_valid_o) begin
      if (expected_updates.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        exp_upd = expected_updates.pop_front();
        if (accepted_o !== exp_upd.accepted)
          report_mismatch($sformatf("accepted %b, expected %b", accepted_o, exp_upd.accepted));
        if (spin_after_o !== exp_upd.spin_after)
          report_mismatch($sformatf("spin_after %b, expected %b",
                                    spin_after_o, exp_upd.spin_after));
        if (delta_energy_o !== exp_upd.de)
          report_mismatch($sformatf("delta_energy %0d, expected %0d",
                                    delta_energy_o, exp_upd.de));
        if (total_energy_o !== exp_upd.energy)
          report_mismatch($sformatf("total_energy %0d, expected %0d",
                                    total_energy_o, exp_upd.energy));
        if (total_magnetization_o !== exp_upd.mag)
          report_mismatch($sformatf("total_magnetization %0d, expected %0d",
                                    total_magnetization_o, exp_upd.mag));
      end
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    logic [ThrW-1:0] phase_de4 [RANDOM_PHASES];
    logic [ThrW-1:0] phase_de8 [RANDOM_PHASES];
    int unsigned     phase_idle [RANDOM_PHASES];
    for (int i = 0; i < SITES; i++) site_spin[i] = 1'b1;
    energy_sum = -2 * SITES;
    magnet_sum = SITES;
    thr_de4 = THR_DE4_RESET;
    thr_de8 = THR_DE8_RESET;

    phase_de4[0] = '0;            phase_de8[0] = '0;            phase_idle[0] = 20;
    phase_de4[1] = ThrW'(65536);  phase_de8[1] = ThrW'(65536);  phase_idle[1] = 20;
    phase_de4[2] = ThrW'($urandom_range(65536));
    phase_de8[2] = ThrW'($urandom_range(65536));                phase_idle[2] = 84;
    phase_de4[3] = '1;            phase_de8[3] = '0;            phase_idle[3] = 84;
    phase_de4[4] = ThrW'($urandom_range(65536));
    phase_de8[4] = ThrW'($urandom_range(65536));                phase_idle[4] = 0;
    phase_de4[5] = THR_DE4_RESET; phase_de8[5] = ThrW'(65536);  phase_idle[5] = 0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed pass under the reset thresholds
    idle_pct = 20;
    pending_requests.push_back(make_req(REQ_READ, 0, 0, 0, 0));
    pending_requests.push_back(make_req(REQ_UNUSED, 31, 31, 65535, 1));
    pending_requests.push_back(make_req(REQ_STEP, 0, 0, 0, 0));
    pending_requests.push_back(make_req(REQ_STEP, 0, 0, 65535, 1));
    pending_requests.push_back(make_req(REQ_STEP, 31, 31, 1200, 0));
    pending_requests.push_back(make_req(REQ_STEP, 31, 31, 1199, 0));
    pending_requests.push_back(make_req(REQ_STEP, 31, 31, 65535, 0));
    pending_requests.push_back(make_req(REQ_WRITE, 5, 5, 0, 1));
    pending_requests.push_back(make_req(REQ_WRITE, 5, 5, 0, 0));
    pending_requests.push_back(make_req(REQ_WRITE, 5, 6, 0, 0));
    pending_requests.push_back(make_req(REQ_STEP, 5, 7, 8868, 0));
    pending_requests.push_back(make_req(REQ_STEP, 5, 8, 8869, 0));
    pending_requests.push_back(make_req(REQ_STEP, 5, 6, 65535, 0));
    pending_requests.push_back(make_req(REQ_WRITE, 4, 6, 0, 0));
    pending_requests.push_back(make_req(REQ_WRITE, 4, 7, 0, 0));
    pending_requests.push_back(make_req(REQ_STEP, 4, 6, 65535, 0));
    pending_requests.push_back(make_req(REQ_READ, 4, 6, 65535, 1));
    pending_requests.push_back(make_req(REQ_WRITE, 31, 0, 65535, 0));
    pending_requests.push_back(make_req(REQ_STEP, 0, 31, 0, 1));
    pending_requests.push_back(make_req(REQ_READ, 16, 21, 21845, 0));
    pending_requests.push_back(make_req(REQ_WRITE, 10, 10, 43690, 1));
    wait_quiet();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      program_thresholds(phase_de4[p], phase_de8[p], (p % 2) == 0);
      idle_pct = phase_idle[p];
      for (int i = 0; i < ITEMS_PER_PHASE; i++) pending_requests.push_back(random_req());
      wait_quiet();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/isi_pkg.sv
hw/rtl/isi_lattice.sv
hw/rtl/ising_metropolis_spin_update.sv
hw/rtl/isi_checker.sv
test/ising_metropolis_spin_update_tb.sv
